FILE: sv/bpte_pkg.sv
`timescale 1ns / 1ps
package bpte_pkg;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_COUNT  = 3'd4,
        REQ_SUM    = 3'd5,
        REQ_MAXMIN = 3'd6,
        REQ_SORT   = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_FULL       = 2'd1,
        STS_EMPTY      = 2'd2,
        STS_NOT_FOUND  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REMOVE_RD,
        ST_REMOVE_WAIT,
        ST_SCAN,
        ST_SRT_NEXT,
        ST_SRT_RDV,
        ST_SRT_LDV,
        ST_SRT_RDP,
        ST_SRT_CMP,
        ST_DONE
    } t_state;

    localparam int unsigned VAL_W  = 31;
    localparam int unsigned SUM_W  = 38;
    localparam int unsigned OUT_W  = 160;
    localparam int unsigned IN_W   = 32;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_last;
        logic take_last;
        logic scan_step;
        logic srt_rd_i;
        logic srt_ld_v;
        logic srt_rd_p;
        logic srt_place_v;
        logic srt_cmp;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic move;
        logic empty;
        logic more;
        logic rd_pend;
        logic j_zero;
        logic out_free;
    } t_stat;

endpackage

FILE: sv/bpte_ctrl.sv
`timescale 1ns / 1ps
module bpte_ctrl
    import bpte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic [2:0] i_req,
    input  t_stat      i_stat,
    output logic       o_s_tready,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    case (t_req'(i_req))
                        REQ_CLEAR, REQ_APPEND: n_state = ST_DONE;
                        REQ_REMOVE: n_state = i_stat.empty ? ST_DONE : ST_REMOVE_RD;
                        REQ_SORT:   n_state = ST_SRT_NEXT;
                        default:    n_state = ST_SCAN;
                    endcase
                end
            end
            ST_REMOVE_RD: begin
                o_cmd.rd_last = 1'b1;
                n_state = ST_REMOVE_WAIT;
            end
            ST_REMOVE_WAIT: begin
                o_cmd.take_last = 1'b1;
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (!i_stat.more && !i_stat.rd_pend) n_state = ST_DONE;
            end
            ST_SRT_NEXT: begin
                n_state = i_stat.more ? ST_SRT_RDV : ST_DONE;
            end
            ST_SRT_RDV: begin
                o_cmd.srt_rd_i = 1'b1;
                n_state = ST_SRT_LDV;
            end
            ST_SRT_LDV: begin
                o_cmd.srt_ld_v = 1'b1;
                n_state = ST_SRT_RDP;
            end
            ST_SRT_RDP: begin
                if (i_stat.j_zero) begin
                    o_cmd.srt_place_v = 1'b1;
                    n_state = ST_SRT_NEXT;
                end else begin
                    o_cmd.srt_rd_p = 1'b1;
                    n_state = ST_SRT_CMP;
                end
            end
            ST_SRT_CMP: begin
                // datapath either shifts the entry ahead of v up when it belongs after v, or drops v in place
                o_cmd.srt_cmp = 1'b1;
                n_state = i_stat.move ? ST_SRT_RDP : ST_SRT_NEXT;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: sv/bpte_dp.sv
`timescale 1ns / 1ps
module bpte_dp
    import bpte_pkg::*;
#(
    parameter int unsigned CAPACITY = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [2:0]         i_req,
    input  logic [VAL_W-1:0]   i_value,
    input  logic               i_asc,
    input  logic               i_m_tready,
    output t_stat              o_stat,
    output logic               o_m_tvalid,
    output logic [OUT_W-1:0]   o_m_tdata
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;
    logic [AW-1:0]    w_raddr;
    logic [AW-1:0]    w_waddr;
    logic [VAL_W-1:0] w_wdata;
    logic             w_we;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_i;
    logic [AW-1:0]    r_j;
    logic [AW-1:0]    r_pi;
    logic             r_pend;
    t_req             r_req;
    logic [VAL_W-1:0] r_key;
    logic             r_asc;
    logic [VAL_W-1:0] r_v;
    logic             r_found;
    logic [AW-1:0]    r_pos;
    logic [CW-1:0]    r_kcnt;
    logic [SUM_W-1:0] r_sum;
    logic [VAL_W-1:0] r_mx;
    logic [VAL_W-1:0] r_mn;
    t_status          r_status;
    logic [VAL_W-1:0] r_removed;
    logic             r_ovalid;
    logic [OUT_W-1:0] r_odata;

    logic w_full, w_empty, w_more, w_move;
    logic [CW-1:0] w_last;

    assign w_full  = (r_count == CAP_C);
    assign w_empty = (r_count == '0);
    assign w_more  = (r_i < r_count);
    assign w_last  = r_count - CW'(1);
    assign w_move  = r_asc ? (r_rdata > r_v) : (r_rdata < r_v);

    assign o_stat.move     = w_move;
    assign o_stat.empty    = w_empty;
    assign o_stat.more     = w_more;
    assign o_stat.rd_pend  = r_pend;
    assign o_stat.j_zero   = (r_j == '0);
    assign o_stat.out_free = !r_ovalid || i_m_tready;

    // single read port, single write port
    always_comb begin
        w_raddr = r_i[AW-1:0];
        if (i_cmd.rd_last) w_raddr = w_last[AW-1:0];
        if (i_cmd.srt_rd_p) w_raddr = r_j - AW'(1);
        w_we    = 1'b0;
        w_waddr = r_j;
        w_wdata = r_v;
        if (i_cmd.capture && t_req'(i_req) == REQ_APPEND && !w_full) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
            w_wdata = i_value;
        end
        if (i_cmd.srt_place_v) w_we = 1'b1;
        if (i_cmd.srt_cmp) begin
            w_we    = 1'b1;
            w_wdata = w_move ? r_rdata : r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_pend <= 1'b0;
                case (t_req'(i_req))
                    REQ_CLEAR:  r_count <= '0;
                    REQ_APPEND: if (!w_full) r_count <= r_count + CW'(1);
                    default: ;
                endcase
            end
            if (i_cmd.take_last) r_count <= w_last;
            if (i_cmd.scan_step) r_pend <= w_more;
            if (i_cmd.load_out) r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req     <= t_req'(i_req);
            r_key     <= i_value;
            r_asc     <= i_asc;
            r_i       <= (t_req'(i_req) == REQ_SORT) ? CW'(1) : '0;
            r_found   <= 1'b0;
            r_pos     <= '0;
            r_kcnt    <= '0;
            r_sum     <= '0;
            r_mx      <= '0;
            r_mn      <= '1;
            r_removed <= '0;
            if (t_req'(i_req) == REQ_APPEND && w_full) r_status <= STS_FULL;
            else if (t_req'(i_req) == REQ_REMOVE && w_empty) r_status <= STS_EMPTY;
            else r_status <= STS_OK;
        end
        if (i_cmd.take_last) r_removed <= r_rdata;
        if (i_cmd.scan_step) begin
            if (w_more) begin
                r_i  <= r_i + CW'(1);
                r_pi <= r_i[AW-1:0];
            end
            if (r_pend) begin
                if (r_rdata == r_key) begin
                    r_kcnt <= r_kcnt + CW'(1);
                    if (!r_found) begin
                        r_found <= 1'b1;
                        r_pos   <= r_pi;
                    end
                end
                r_sum <= r_sum + SUM_W'(r_rdata);
                if (r_rdata > r_mx) r_mx <= r_rdata;
                if (r_rdata < r_mn) r_mn <= r_rdata;
            end
        end
        if (i_cmd.srt_rd_i) r_j <= r_i[AW-1:0];
        if (i_cmd.srt_ld_v) r_v <= r_rdata;
        if (i_cmd.srt_place_v || (i_cmd.srt_cmp && !w_move)) begin
            r_i <= r_i + CW'(1);
            r_j <= '0;
        end else if (i_cmd.srt_cmp) begin
            r_j <= r_j - AW'(1);
        end
        if (i_cmd.load_out) begin
            r_odata[OUT_W-1:158] <= '0;
            r_odata[1:0]     <= (r_req == REQ_SEARCH && !r_found) ? STS_NOT_FOUND : r_status;
            r_odata[8:2]     <= (r_req == REQ_SEARCH) ? 7'(r_pos) : '0;
            r_odata[16:9]    <= (r_req == REQ_COUNT) ? 8'(r_kcnt) : '0;
            r_odata[47:17]   <= r_removed;
            r_odata[85:48]   <= (r_req == REQ_SUM) ? r_sum : '0;
            r_odata[116:86]  <= (r_req == REQ_MAXMIN) ? r_mx : '0;
            r_odata[147:117] <= (r_req == REQ_MAXMIN && !w_empty) ? r_mn : '0;
            r_odata[155:148] <= 8'(r_count);
            r_odata[156]     <= w_full;
            r_odata[157]     <= w_empty;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

FILE: sv/bounded_positive_table_engine.sv
`timescale 1ns / 1ps
// Bounded table of up to CAPACITY 31-bit values packed from position zero. Each
// request on the slave stream (tuser = operation code) clears, appends, removes the
// last entry, searches or counts a key, sums, finds max/min or sorts in place, and
// yields one result transfer with status, count and full/empty flags. Search,
// count, sum and max/min read one stored entry per cycle through the single read
// port of the table memory; sort is an insertion sort through that same read port.
// A new request is taken as soon as the previous result sits in the output
// register, even if the master side has not yet taken it. The table needs no
// clearing pass.
module bounded_positive_table_engine
    import bpte_pkg::*;
#(
    parameter int unsigned CAPACITY = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // [30:0] value, [31] sort_ascending
    input  logic [IN_W-1:0]   i_s_tdata,
    // [2:0] req_type
    input  logic [2:0]        i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [1:0] status, [8:2] found_position, [16:9] key_count, [47:17] removed_value,
    // [85:48] total_sum, [116:86] max_value, [147:117] min_value,
    // [155:148] element_count, [156] is_full, [157] is_empty, rest zero
    output logic [OUT_W-1:0]  o_m_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    bpte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req      (i_s_tuser),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    bpte_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req      (i_s_tuser),
        .i_value    (i_s_tdata[30:0]),
        .i_asc      (i_s_tdata[31]),
        .i_m_tready (i_m_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    // a result never claims full and empty together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[156] && o_m_tdata[157]))
        else $error("full and empty both set");

    // after taking a request the engine is busy in the cycle after
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while busy");

endmodule
